// ----- hdl/mtc_pkg.sv -----
// Shared types and constants for the MIDI time code assembler.
// No dependencies; imported by mtc_decode and mtc_timecode_assembler.
package mtc_pkg;

  // Message kinds carried on the input tuser
  localparam logic [1:0] OP_QUARTER_FRAME = 2'd0;
  localparam logic [1:0] OP_SYSEX         = 2'd1;

  // Full-frame SysEx header bytes
  localparam logic [7:0] SX_ID_RT     = 8'h7F;
  localparam logic [7:0] SX_DEVICE_ALL = 8'h7F;
  localparam logic [7:0] SX_SUB_MTC   = 8'h01;

  // Last quarter-frame part (carries hours high bit and rate type) and first part
  localparam logic [2:0] PART_LAST  = 3'd7;
  localparam logic [2:0] PART_FIRST = 3'd0;

  localparam int IN_DATA_W  = 64;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 40;

  // One input word, unpacked
  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] qf_data;
    logic [7:0] sx_id_byte;
    logic [7:0] sx_device_byte;
    logic [7:0] sx_sub_byte;
    logic [7:0] sx_hour_byte;
    logic [7:0] sx_minute_byte;
    logic [7:0] sx_second_byte;
    logic [7:0] sx_frame_byte;
  } item_t;

  // Decoder result towards the output register
  typedef struct packed {
    logic       emit;
    logic [4:0] hours;
    logic [7:0] minutes;
    logic [7:0] seconds;
    logic [7:0] frames;
    logic [2:0] rate_type;
    logic       type_changed;
  } result_t;

endpackage

// ----- hdl/mtc_decode.sv -----
// Quarter-frame nibble store, direction tracking and rate-type change flag.
// Depends on mtc_pkg. Combinational result, state updated on step.
module mtc_decode import mtc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    step,
  input  item_t   item,
  output result_t res
);

  logic [3:0] nibble_store [8];
  logic [3:0] store_new    [8];
  logic [2:0] last_part;
  logic       running_forward;
  logic [2:0] reported_type;
  logic       reported_type_known;

  logic [2:0] part;
  logic [3:0] nib;
  logic       is_qf;
  logic       sx_ok;
  logic       dir_next;
  logic       qf_fire;
  logic [2:0] type_sel;

  assign part  = item.qf_data[6:4];
  assign nib   = item.qf_data[3:0];
  assign is_qf = (item.opcode == OP_QUARTER_FRAME);
  assign sx_ok = (item.opcode == OP_SYSEX) && (item.sx_id_byte == SX_ID_RT) &&
                 (item.sx_device_byte == SX_DEVICE_ALL) &&
                 (item.sx_sub_byte == SX_SUB_MTC);

  // Store as it looks with this word's nibble written in
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      store_new[i] = (part == 3'(i)) ? nib : nibble_store[i];
    end
  end

  // Direction only follows parts 0..6 on both sides
  assign dir_next = (part != PART_LAST && last_part != PART_LAST) ?
                    (last_part < part) : running_forward;
  assign qf_fire  = is_qf && ((dir_next && part == PART_LAST) ||
                              (!dir_next && part == PART_FIRST));

  // Result assembly
  always_comb begin
    res = '0;
    if (sx_ok) begin
      res.emit      = 1'b1;
      res.hours     = item.sx_hour_byte[4:0];
      res.minutes   = item.sx_minute_byte;
      res.seconds   = item.sx_second_byte;
      res.frames    = item.sx_frame_byte;
      res.rate_type = item.sx_hour_byte[7:5];
    end else begin
      res.emit      = qf_fire;
      res.hours     = {store_new[7][0], store_new[6]};
      res.minutes   = {store_new[5], store_new[4]};
      res.seconds   = {store_new[3], store_new[2]};
      res.frames    = {store_new[1], store_new[0]};
      res.rate_type = store_new[7][3:1];
    end
    res.type_changed = !reported_type_known || (reported_type != res.rate_type);
  end

  assign type_sel = res.rate_type;

  // State update
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 8; i++) nibble_store[i] <= '0;
      last_part           <= '0;
      running_forward     <= 1'b1;
      reported_type       <= '0;
      reported_type_known <= 1'b0;
    end else if (step) begin
      if (is_qf) begin
        nibble_store[part] <= nib;
        last_part          <= part;
        running_forward    <= dir_next;
      end
      if (res.emit) begin
        reported_type       <= type_sel;
        reported_type_known <= 1'b1;
      end
    end
  end

  // Checks
  a_known_after_emit: assert property (@(posedge clk) disable iff (rst)
    step && res.emit |=> reported_type_known)
    else $error("rate type not marked known after a report");

  a_sysex_emits: assert property (@(posedge clk) disable iff (rst)
    step && sx_ok |-> res.emit)
    else $error("time code SysEx gave no result");

  a_other_keeps_state: assert property (@(posedge clk) disable iff (rst)
    step && item.opcode != OP_QUARTER_FRAME && item.opcode != OP_SYSEX |=>
    $stable(last_part) && $stable(running_forward) && $stable(reported_type))
    else $error("ignored message changed state");

  a_reported_tracks: assert property (@(posedge clk) disable iff (rst)
    step && res.emit |=> reported_type == $past(res.rate_type))
    else $error("reported type not updated");

endmodule

// ----- hdl/mtc_timecode_assembler.sv -----
// Top level of the MIDI time code assembler: input register, decoder, output register.
// Depends on mtc_pkg and mtc_decode.
//
// Takes one classified MIDI time code word per clock cycle. When part 7
// (running forward) or part 0 (running backward) of a quarter-frame set
// arrives, or on a full-frame SysEx (7F 7F 01), the assembled time code is
// loaded into the output register after the word has passed the input register
// and the decoder; m_tvalid comes from the output register. A word whose result
// finds the output register full waits. Words that give no result pass with no output.
// Throughput is one word per cycle. It drops only while the output register
// holds a result that the sink has not taken.
module mtc_timecode_assembler import mtc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // qf_data, sx_id_byte, sx_device_byte, sx_sub_byte, sx_hour_byte,
  // sx_minute_byte, sx_second_byte, sx_frame_byte
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // opcode
  input  logic [IN_USER_W-1:0]  s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // hours, minutes, seconds, frames, rate_type, type_changed, zero pad
  output logic [OUT_DATA_W-1:0] m_tdata
);

  logic                 in_valid;
  logic [IN_DATA_W-1:0] in_data;
  logic [IN_USER_W-1:0] in_user;
  item_t                item;
  result_t              res;
  logic                 advance;
  logic                 out_free;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_data <= s_tdata;
      in_user <= s_tuser;
    end
  end

  assign item = '{opcode:         in_user,
                  qf_data:        in_data[7:0],
                  sx_id_byte:     in_data[15:8],
                  sx_device_byte: in_data[23:16],
                  sx_sub_byte:    in_data[31:24],
                  sx_hour_byte:   in_data[39:32],
                  sx_minute_byte: in_data[47:40],
                  sx_second_byte: in_data[55:48],
                  sx_frame_byte:  in_data[63:56]};

  // A word moves on unless its result would overwrite one still waiting
  assign out_free = !m_tvalid || m_tready;
  assign advance  = in_valid && (!res.emit || out_free);
  assign s_tready = !in_valid || advance;

  mtc_decode u_decode (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .item (item),
    .res  (res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && res.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.emit) begin
      m_tdata <= {7'b0, res.type_changed, res.rate_type, res.frames,
                  res.seconds, res.minutes, res.hours};
    end
  end

  // Checks
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !(advance && res.emit))
    else $error("pending result overwritten");

  a_in_held: assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid && $stable(in_data))
    else $error("stalled input word lost");

  a_emit_loads: assert property (@(posedge clk) disable iff (rst)
    advance && res.emit |=> m_tvalid)
    else $error("result not presented");

endmodule
